// File: sv/i2c_master_byte_sequencer_top_defines.svh
// Assertion macros shared by the sequencer modules.
`ifndef I2C_MASTER_BYTE_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CMS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/i2cms_pkg.sv
package i2cms_pkg;

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int COUNTER_BITS_DEF = 16;
  localparam int Q_DEPTH     = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_WAIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_TOUT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] BIT_TIME_RST   = 16'd10;
  localparam logic [CFG_W-1:0] ACK_WAIT_RST   = 16'd10;
  localparam logic [CFG_W-1:0] TRANS_TOUT_RST = 16'd100;

  // Input kind codes.
  localparam logic [2:0] KIND_START     = 3'd1;
  localparam logic [2:0] KIND_STOP      = 3'd2;
  localparam logic [2:0] KIND_WRITE     = 3'd3;
  localparam logic [2:0] KIND_READ_ACK  = 3'd4;
  localparam logic [2:0] KIND_READ_NACK = 3'd5;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ_ACK,
    CMD_READ_NACK
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       sda_in;
    logic       ms_tick;
  } in_word_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       cmd_done;
    logic [7:0] rx_byte;
    logic       status;
    logic       rejected;
  } out_word_t;

  // Classified word held in the queue between front and engine.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
    logic       ms_tick;
  } q_word_t;

endpackage

// File: sv/i2cms_front.sv
`include "i2c_master_byte_sequencer_top_defines.svh"

module i2cms_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2cms_pkg::in_word_t  in_data,
  output logic                 q_valid,
  input  logic                 q_pop,
  output i2cms_pkg::q_word_t   q_data
);

  localparam int PtrW = (i2cms_pkg::Q_DEPTH > 1) ? $clog2(i2cms_pkg::Q_DEPTH) : 1;
  localparam int CntW = $clog2(i2cms_pkg::Q_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(i2cms_pkg::Q_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(i2cms_pkg::Q_DEPTH - 1);

  i2cms_pkg::q_word_t q_mem_r [i2cms_pkg::Q_DEPTH];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  i2cms_pkg::q_word_t cls;
  logic               push;

  // Decode the raw kind; unused codes behave as a plain tick.
  always_comb begin
    cls.tx_byte = in_data.tx_byte;
    cls.sda_in  = in_data.sda_in;
    cls.ms_tick = in_data.ms_tick;
    unique case (in_data.kind)
      i2cms_pkg::KIND_START:     cls.cmd = i2cms_pkg::CMD_START;
      i2cms_pkg::KIND_STOP:      cls.cmd = i2cms_pkg::CMD_STOP;
      i2cms_pkg::KIND_WRITE:     cls.cmd = i2cms_pkg::CMD_WRITE;
      i2cms_pkg::KIND_READ_ACK:  cls.cmd = i2cms_pkg::CMD_READ_ACK;
      i2cms_pkg::KIND_READ_NACK: cls.cmd = i2cms_pkg::CMD_READ_NACK;
      default:                   cls.cmd = i2cms_pkg::CMD_TICK;
    endcase
  end

  assign in_stall = (cnt_r == DepthC);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  `I2CMS_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= DepthC, "queue count overflow")
  `I2CMS_ASSERT_SAME(a_pop_nonempty, clk, rst_n, q_pop, cnt_r != '0, "pop from empty queue")

endmodule

// File: sv/i2cms_engine.sv
`include "i2c_master_byte_sequencer_top_defines.svh"

module i2cms_engine #(
  parameter int COUNTER_BITS = i2cms_pkg::COUNTER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2cms_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                q_valid,
  input  i2cms_pkg::q_word_t                  q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output i2cms_pkg::out_word_t                out_data
);

  localparam int CmpW = (COUNTER_BITS > i2cms_pkg::CFG_W) ? COUNTER_BITS : i2cms_pkg::CFG_W;
  localparam logic [COUNTER_BITS-1:0] CntMax = '1;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_TS1, PH_TS2,
    PH_WSET, PH_WHI, PH_WLO, PH_ASET, PH_APOLL, PH_AHOLD,
    PH_RLO, PH_RHI, PH_RHOLD, PH_RFALL, PH_RACK
  } phase_t;

  logic [i2cms_pkg::CFG_W-1:0] bit_time_r, ack_wait_r, trans_tout_r;

  phase_t                  phase_r, phase_nxt;
  logic [3:0]              bit_cnt_r, bit_cnt_nxt;
  logic [COUNTER_BITS-1:0] delay_r, delay_nxt;
  logic [7:0]              shift_r, shift_nxt;
  logic [COUNTER_BITS-1:0] ack_cnt_r, ack_cnt_nxt;
  logic [COUNTER_BITS-1:0] trans_ms_r, trans_ms_nxt;
  logic                    scl_r, scl_nxt;
  logic                    sda_r, sda_nxt;
  logic                    nack_r, nack_nxt;
  logic                    out_valid_r, out_valid_nxt;
  i2cms_pkg::out_word_t    out_data_r;

  logic                        fire;
  logic [COUNTER_BITS-1:0]     delay_inc;
  logic                        half_phase;
  logic [i2cms_pkg::CFG_W-1:0] need;
  logic                        hit;
  logic                        do_enter;
  phase_t                      target;
  logic                        fin;
  logic                        fin_status;
  logic                        rej;
  i2cms_pkg::out_word_t        res;

  assign fire  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = fire;

  assign delay_inc = (delay_r == CntMax) ? delay_r : delay_r + 1'b1;

  always_comb begin
    case (phase_r) inside
      PH_WSET, PH_WLO, PH_ASET, PH_AHOLD,
      PH_RLO, PH_RHI, PH_RHOLD, PH_RFALL: half_phase = 1'b1;
      default:                            half_phase = 1'b0;
    endcase
  end

  assign need = half_phase ? (bit_time_r >> 1) : bit_time_r;
  // A phase also ends once the saturating delay counter tops out.
  assign hit  = (CmpW'(delay_inc) >= CmpW'(need)) || (delay_inc == CntMax);

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    delay_nxt    = delay_r;
    shift_nxt    = shift_r;
    ack_cnt_nxt  = ack_cnt_r;
    trans_ms_nxt = trans_ms_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    nack_nxt     = nack_r;
    do_enter     = 1'b0;
    target       = PH_IDLE;
    fin          = 1'b0;
    fin_status   = 1'b0;
    rej          = 1'b0;

    if (fire) begin
      if (q_data.ms_tick) begin
        trans_ms_nxt = (trans_ms_r == CntMax) ? trans_ms_r : trans_ms_r + 1'b1;
        if (phase_r == PH_ASET || phase_r == PH_APOLL) begin
          ack_cnt_nxt = (ack_cnt_r == CntMax) ? ack_cnt_r : ack_cnt_r + 1'b1;
        end
      end

      if (phase_r != PH_IDLE) begin
        rej = (q_data.cmd != i2cms_pkg::CMD_TICK);
        if (phase_r != PH_APOLL) begin
          delay_nxt = delay_inc;
        end
        unique case (phase_r) inside
          PH_ST1: if (hit) begin do_enter = 1'b1; target = PH_ST2; end
          PH_ST2: if (hit) begin scl_nxt = 1'b0; fin = 1'b1; end
          PH_SP1: if (hit) begin do_enter = 1'b1; target = PH_SP2; end
          PH_SP2: if (hit) begin fin = 1'b1; end
          PH_TS1: if (hit) begin do_enter = 1'b1; target = PH_TS2; end
          PH_TS2: if (hit) begin fin = 1'b1; fin_status = 1'b1; end
          PH_WSET: if (hit) begin do_enter = 1'b1; target = PH_WHI; end
          PH_WHI: if (hit) begin do_enter = 1'b1; target = PH_WLO; end
          PH_WLO: begin
            if (hit) begin
              shift_nxt   = {shift_r[6:0], 1'b0};
              bit_cnt_nxt = bit_cnt_r + 1'b1;
              do_enter    = 1'b1;
              target      = (bit_cnt_nxt >= 4'd8) ? PH_ASET : PH_WSET;
            end
          end
          PH_ASET: if (hit) begin do_enter = 1'b1; target = PH_APOLL; end
          PH_APOLL: begin
            if (!q_data.sda_in) begin
              do_enter = 1'b1;
              target   = PH_AHOLD;
            end else if (CmpW'(ack_cnt_nxt) > CmpW'(ack_wait_r)) begin
              do_enter = 1'b1;
              target   = PH_TS1;
            end
          end
          PH_RLO: if (hit) begin do_enter = 1'b1; target = PH_RHI; end
          PH_RHI: begin
            if (hit) begin
              shift_nxt = {shift_r[6:0], q_data.sda_in};
              do_enter  = 1'b1;
              target    = PH_RHOLD;
            end
          end
          PH_RHOLD: if (hit) begin do_enter = 1'b1; target = PH_RFALL; end
          PH_RFALL: begin
            if (hit) begin
              bit_cnt_nxt = bit_cnt_r + 1'b1;
              do_enter    = 1'b1;
              target      = (bit_cnt_nxt >= 4'd8) ? PH_RACK : PH_RLO;
            end
          end
          PH_AHOLD, PH_RACK: begin
            // End of the byte: check the transaction deadline.
            if (hit) begin
              scl_nxt = 1'b0;
              if (CmpW'(trans_ms_nxt) > CmpW'(trans_tout_r)) begin
                do_enter = 1'b1;
                target   = PH_TS1;
              end else begin
                fin = 1'b1;
              end
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end else begin
        case (q_data.cmd) inside
          i2cms_pkg::CMD_START: begin
            trans_ms_nxt = '0;
            shift_nxt    = '0;
            do_enter     = 1'b1;
            target       = PH_ST1;
          end
          i2cms_pkg::CMD_STOP: begin
            shift_nxt = '0;
            do_enter  = 1'b1;
            target    = PH_SP1;
          end
          i2cms_pkg::CMD_WRITE: begin
            shift_nxt   = q_data.tx_byte;
            bit_cnt_nxt = '0;
            do_enter    = 1'b1;
            target      = PH_WSET;
          end
          i2cms_pkg::CMD_READ_ACK, i2cms_pkg::CMD_READ_NACK: begin
            shift_nxt   = '0;
            bit_cnt_nxt = '0;
            nack_nxt    = (q_data.cmd == i2cms_pkg::CMD_READ_NACK);
            sda_nxt     = 1'b1;
            do_enter    = 1'b1;
            target      = PH_RLO;
          end
          default: ;
        endcase
      end

      if (do_enter) begin
        phase_nxt = target;
        delay_nxt = '0;
        case (target) inside
          PH_ST1: begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
          PH_ST2: sda_nxt = 1'b0;
          PH_SP1, PH_TS1: begin sda_nxt = 1'b0; scl_nxt = 1'b1; end
          PH_SP2, PH_TS2: sda_nxt = 1'b1;
          PH_WSET: begin scl_nxt = 1'b0; sda_nxt = shift_nxt[7]; end
          PH_WHI, PH_RHI: scl_nxt = 1'b1;
          PH_WLO, PH_RLO, PH_RFALL: scl_nxt = 1'b0;
          PH_ASET: begin sda_nxt = 1'b1; scl_nxt = 1'b1; ack_cnt_nxt = '0; end
          PH_RACK: begin sda_nxt = nack_nxt; scl_nxt = 1'b1; end
          default: ;
        endcase
      end
      if (fin) begin
        phase_nxt = PH_IDLE;
        delay_nxt = '0;
      end
    end
  end

  always_comb begin
    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (phase_nxt != PH_IDLE);
    res.cmd_done = fin;
    res.rx_byte  = fin ? shift_nxt : 8'd0;
    res.status   = fin && fin_status;
    res.rejected = rej;
  end

  assign out_valid_nxt = fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_time_r   <= i2cms_pkg::BIT_TIME_RST;
      ack_wait_r   <= i2cms_pkg::ACK_WAIT_RST;
      trans_tout_r <= i2cms_pkg::TRANS_TOUT_RST;
      phase_r      <= PH_IDLE;
      bit_cnt_r    <= '0;
      delay_r      <= '0;
      shift_r      <= '0;
      ack_cnt_r    <= '0;
      trans_ms_r   <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      nack_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          i2cms_pkg::REG_BIT_TIME:   bit_time_r   <= cfg_data;
          i2cms_pkg::REG_ACK_WAIT:   ack_wait_r   <= cfg_data;
          i2cms_pkg::REG_TRANS_TOUT: trans_tout_r <= cfg_data;
          default: ;
        endcase
      end
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      delay_r     <= delay_nxt;
      shift_r     <= shift_nxt;
      ack_cnt_r   <= ack_cnt_nxt;
      trans_ms_r  <= trans_ms_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      nack_r      <= nack_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        out_data_r <= res;
      end
    end
  end

  `I2CMS_ASSERT_SAME(a_done_not_busy, clk, rst_n, out_valid_r && out_data_r.cmd_done,
    !out_data_r.busy_res, "command done while still busy")
  `I2CMS_ASSERT_SAME(a_quiet_fields, clk, rst_n, out_valid_r && !out_data_r.cmd_done,
    out_data_r.rx_byte == 8'd0 && !out_data_r.status, "byte or status without completion")
  `I2CMS_ASSERT_NEXT(a_start_enters, clk, rst_n,
    fire && phase_r == PH_IDLE && q_data.cmd == i2cms_pkg::CMD_START,
    phase_r == PH_ST1, "start command did not enter the start phase")

endmodule

// File: sv/i2c_master_byte_sequencer_top.sv
// I2C master byte sequencer. Each input word is one timebase tick and may carry a
// command (start, stop, write byte, read byte with ACK or NACK) together with the
// sampled SDA level and a millisecond strobe. Every accepted input word yields
// exactly one result word with the SCL/SDA levels after that tick, busy, done,
// the received byte, a timeout status and a rejected flag.
// Channels: in_valid/in_stall and out_valid/out_stall; a word moves when valid is
// high and stall is low. Configuration writes use cfg_valid/cfg_ready with a
// register index (0 bit time, 1 ACK wait, 2 transaction timeout) and are always
// taken; they must only be issued while no words are in flight.
// The input word is written into the queue, popped by the engine, and its result is
// registered in the output register before out_valid rises.
// Throughput: one word per clock while the receiver does not stall; a two-entry
// queue between the decoder and the engine and the output register let both
// sides stall independently.
// When the receiver stalls, the result is held, the queue fills and in_stall
// rises once it holds two words.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid, returns the
// engine to idle with both lines released and loads the default register values.
module i2c_master_byte_sequencer_top #(
  parameter int COUNTER_BITS = i2cms_pkg::COUNTER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  i2cms_pkg::in_word_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output i2cms_pkg::out_word_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cms_pkg::CFG_W-1:0]      cfg_data
);

  logic               q_valid;
  logic               q_pop;
  i2cms_pkg::q_word_t q_data;
  logic               cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  i2cms_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  i2cms_engine #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
